// File: src/u16u8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and helpers of the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

    localparam int BYTE_COUNT_BITS_DEF = 22;
    localparam int UNIT_COUNT_BITS_DEF = 20;

    localparam int UNIT_W      = 16;
    localparam int BUDGET_W    = 22;
    localparam int UNITS_OUT_W = 20;
    localparam int BYTES_OUT_W = 22;
    localparam int S_DATA_W    = 16;
    localparam int M_DATA_W    = 56;
    localparam int M_USER_W    = 2;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 22'h3FFFFF;

    // Register word index of byte_budget.
    localparam logic [0:0] REG_BYTE_BUDGET = 1'b0;

    localparam logic [UNIT_W-1:0] SURR_LO      = 16'hD800;
    localparam logic [UNIT_W-1:0] LOW_SURR_LO  = 16'hDC00;
    localparam logic [UNIT_W-1:0] SURR_HI      = 16'hDFFF;
    localparam logic [UNIT_W-1:0] ONE_BYTE_LIM = 16'h0080;
    localparam logic [UNIT_W-1:0] TWO_BYTE_LIM = 16'h0800;
    localparam logic [20:0]       SUPP_BASE    = 21'h10000;

    localparam logic [7:0] LEAD4 = 8'd240;
    localparam logic [7:0] LEAD3 = 8'd224;
    localparam logic [7:0] LEAD2 = 8'd192;
    localparam logic [7:0] CONT  = 8'd128;

    localparam logic [31:0] MARKER = {8'd189, 8'd191, 8'd239, 8'h5C};

    // One queued item: up to four bytes with the per-beat side fields.
    typedef struct packed {
        logic [3:0][7:0]        bytes;
        logic [1:0]             last_idx;
        logic                   byte_valid;
        logic                   overflow;
        logic [UNITS_OUT_W-1:0] units_used;
        logic [BYTES_OUT_W-1:0] bytes_used;
    } job_t;

    function automatic logic is_surr(input logic [UNIT_W-1:0] u);
        return (u >= SURR_LO) && (u <= SURR_HI);
    endfunction

    function automatic logic is_high(input logic [UNIT_W-1:0] u);
        return (u >= SURR_LO) && (u < LOW_SURR_LO);
    endfunction

    function automatic logic is_low(input logic [UNIT_W-1:0] u);
        return (u >= LOW_SURR_LO) && (u <= SURR_HI);
    endfunction

endpackage

// File: src/utf16_to_utf8_transcoder.sv
`timescale 1ns / 1ps
// Accepted units are queued as jobs; each byte beat is then loaded into the output register.
// Throughput: one output beat per unstalled cycle; a unit takes one to four beats,
// set by its UTF-8 byte count, and up to four units are buffered between the two halves.
// The input takes one unit per cycle while the four-entry job queue has room.
// Reset is synchronous and active low; it clears the string state, queue and output stage
// and restores byte_budget to its largest value.
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// UTF-16 code unit stream to UTF-8 byte stream converter with a per-string
// byte budget and APB configuration.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder #(
    parameter int BYTE_COUNT_BITS = u16u8_pkg::BYTE_COUNT_BITS_DEF,
    parameter int UNIT_COUNT_BITS = u16u8_pkg::UNIT_COUNT_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // code_unit[15:0]
    input  logic [u16u8_pkg::S_DATA_W-1:0]       s_tdata,
    // first_of_string[0]
    input  logic [0:0]                           s_tuser,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_byte[7:0], units_used[27:8], bytes_used[49:28], zero pad[55:50]
    output logic [u16u8_pkg::M_DATA_W-1:0]       m_tdata,
    // byte_valid[0], overflow[1]
    output logic [u16u8_pkg::M_USER_W-1:0]       m_tuser,
    output logic                                 m_tlast,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [u16u8_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [u16u8_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [u16u8_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);

    logic [u16u8_pkg::BUDGET_W-1:0] budget_reg, budget_next;
    logic                           reg_hit;
    logic                           accept;
    logic                           q_full;
    logic                           q_pop;
    logic                           q_head_valid;
    u16u8_pkg::job_t                f_job;
    u16u8_pkg::job_t                q_head_job;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2:2] == u16u8_pkg::REG_BYTE_BUDGET);
    assign prdata  = reg_hit ? u16u8_pkg::APB_DATA_W'(budget_reg) : '0;

    always_comb begin
        budget_next = budget_reg;
        if (psel && penable && pwrite && pready && reg_hit) begin
            budget_next = pwdata[u16u8_pkg::BUDGET_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg <= u16u8_pkg::BUDGET_RESET;
        end else begin
            budget_reg <= budget_next;
        end
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    u16u8_front #(
        .BYTE_COUNT_BITS (BYTE_COUNT_BITS),
        .UNIT_COUNT_BITS (UNIT_COUNT_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .code_unit       (s_tdata),
        .first_of_string (s_tuser[0]),
        .end_of_string   (s_tlast),
        .byte_budget     (budget_reg),
        .job             (f_job)
    );

    u16u8_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .push_job   (f_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    u16u8_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// File: src/u16u8_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, tracks surrogate, counter and halt state, and builds
// one job per unit with its encoded bytes and counts.
// ----------------------------------------------------------------------------
module u16u8_front #(
    parameter int BYTE_COUNT_BITS = u16u8_pkg::BYTE_COUNT_BITS_DEF,
    parameter int UNIT_COUNT_BITS = u16u8_pkg::UNIT_COUNT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             accept,
    input  logic [u16u8_pkg::UNIT_W-1:0]     code_unit,
    input  logic                             first_of_string,
    input  logic                             end_of_string,
    input  logic [u16u8_pkg::BUDGET_W-1:0]   byte_budget,
    output u16u8_pkg::job_t                  job
);

    localparam int BCB = BYTE_COUNT_BITS;
    localparam int UCB = UNIT_COUNT_BITS;
    localparam int CW  = ((BCB > u16u8_pkg::BUDGET_W) ? BCB : u16u8_pkg::BUDGET_W) + 1;
    localparam int UW  = ((UCB > u16u8_pkg::UNITS_OUT_W) ? UCB : u16u8_pkg::UNITS_OUT_W) + 1;
    localparam logic [CW-1:0]  BYTE_MAX = CW'({BCB{1'b1}});
    localparam logic [UCB:0]   UNIT_MAX = {1'b0, {UCB{1'b1}}};

    logic                          pend_valid_reg, pend_valid_next;
    logic [u16u8_pkg::UNIT_W-1:0]  pend_unit_reg, pend_unit_next;
    logic [BCB-1:0]                byte_cnt_reg, byte_cnt_next;
    logic [UCB-1:0]                unit_cnt_reg, unit_cnt_next;
    logic                          halted_reg, halted_next;

    logic                          e_pv;
    logic [u16u8_pkg::UNIT_W-1:0]  e_pu;
    logic [BCB-1:0]                e_bc;
    logic [UCB-1:0]                e_uc;
    logic                          e_halt;
    logic [31:0]                   enc;
    logic [2:0]                    n;
    logic [1:0]                    units;
    logic                          emit;
    logic [20:0]                   cp;
    logic [CW-1:0]                 budget_eff, left, bc_ext, bc_show;
    logic [UCB:0]                  usum;
    logic [UW-1:0]                 uc_show;

    always_comb begin
        e_pv   = first_of_string ? 1'b0 : pend_valid_reg;
        e_pu   = first_of_string ? '0 : pend_unit_reg;
        e_bc   = first_of_string ? '0 : byte_cnt_reg;
        e_uc   = first_of_string ? '0 : unit_cnt_reg;
        e_halt = first_of_string ? 1'b0 : halted_reg;

        cp = ({5'd0, e_pu - u16u8_pkg::SURR_LO} << 10)
           + {5'd0, code_unit - u16u8_pkg::LOW_SURR_LO} + u16u8_pkg::SUPP_BASE;

        enc   = '0;
        n     = 3'd0;
        units = 2'd0;
        emit  = 1'b0;
        pend_valid_next = e_pv;
        pend_unit_next  = e_pu;
        halted_next     = e_halt;
        byte_cnt_next   = e_bc;
        unit_cnt_next   = e_uc;

        if (e_pv) begin
            if (u16u8_pkg::is_high(e_pu) && u16u8_pkg::is_low(code_unit)) begin
                enc = {u16u8_pkg::CONT | {2'b00, cp[5:0]},
                       u16u8_pkg::CONT | {2'b00, cp[11:6]},
                       u16u8_pkg::CONT | {2'b00, cp[17:12]},
                       u16u8_pkg::LEAD4 | {5'd0, cp[20:18]}};
            end else begin
                enc = u16u8_pkg::MARKER;
            end
            n = 3'd4;
            units = 2'd2;
            emit = 1'b1;
        end else if (u16u8_pkg::is_surr(code_unit)) begin
            if (end_of_string) begin
                enc = u16u8_pkg::MARKER;
                n = 3'd4;
                units = 2'd1;
                emit = 1'b1;
            end
        end else if (code_unit < u16u8_pkg::ONE_BYTE_LIM) begin
            enc = {24'd0, code_unit[7:0]};
            n = 3'd1;
            units = 2'd1;
            emit = 1'b1;
        end else if (code_unit < u16u8_pkg::TWO_BYTE_LIM) begin
            enc = {16'd0, u16u8_pkg::CONT | {2'b00, code_unit[5:0]},
                   u16u8_pkg::LEAD2 | {3'd0, code_unit[10:6]}};
            n = 3'd2;
            units = 2'd1;
            emit = 1'b1;
        end else begin
            enc = {8'd0, u16u8_pkg::CONT | {2'b00, code_unit[5:0]},
                   u16u8_pkg::CONT | {2'b00, code_unit[11:6]},
                   u16u8_pkg::LEAD3 | {4'd0, code_unit[15:12]}};
            n = 3'd3;
            units = 2'd1;
            emit = 1'b1;
        end

        budget_eff = (CW'(byte_budget) > BYTE_MAX) ? BYTE_MAX : CW'(byte_budget);
        bc_ext     = CW'(e_bc);
        left       = (bc_ext <= budget_eff) ? (budget_eff - bc_ext) : '0;
        usum       = {1'b0, e_uc} + (UCB+1)'(units);

        job = '0;
        job.last_idx = 2'd0;

        if (e_halt) begin
            job.overflow = 1'b1;
        end else if (!emit) begin
            pend_valid_next = 1'b1;
            pend_unit_next  = code_unit;
        end else begin
            pend_valid_next = 1'b0;
            pend_unit_next  = '0;
            if (CW'(n) > left) begin
                halted_next  = 1'b1;
                job.overflow = 1'b1;
            end else begin
                byte_cnt_next  = e_bc + BCB'(n);
                unit_cnt_next  = (usum > UNIT_MAX) ? UNIT_MAX[UCB-1:0] : usum[UCB-1:0];
                job.bytes      = enc;
                job.last_idx   = 2'(n - 3'd1);
                job.byte_valid = 1'b1;
            end
        end

        bc_show = CW'(byte_cnt_next);
        uc_show = UW'(unit_cnt_next);
        job.bytes_used = bc_show[u16u8_pkg::BYTES_OUT_W-1:0];
        job.units_used = uc_show[u16u8_pkg::UNITS_OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            pend_unit_reg  <= '0;
            byte_cnt_reg   <= '0;
            unit_cnt_reg   <= '0;
            halted_reg     <= 1'b0;
        end else if (accept) begin
            pend_valid_reg <= pend_valid_next;
            pend_unit_reg  <= pend_unit_next;
            byte_cnt_reg   <= byte_cnt_next;
            unit_cnt_reg   <= unit_cnt_next;
            halted_reg     <= halted_next;
        end
    end

endmodule

// File: src/u16u8_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_queue
// Short job queue that decouples the classifying front from the byte
// serializer.
// ----------------------------------------------------------------------------
module u16u8_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  u16u8_pkg::job_t push_job,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output u16u8_pkg::job_t head_job
);

    localparam int DEPTH = u16u8_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    u16u8_pkg::job_t  entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;

    assign full       = (count_reg == (AW+1)'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/u16u8_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_back
// Serializes each queued job into one output beat per byte, or a single
// beat for a job with no byte, through a registered output stage.
// ----------------------------------------------------------------------------
module u16u8_back (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  head_valid,
    input  u16u8_pkg::job_t                       head_job,
    output logic                                  pop,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [u16u8_pkg::M_DATA_W-1:0]        m_tdata,
    output logic [u16u8_pkg::M_USER_W-1:0]        m_tuser,
    output logic                                  m_tlast
);

    logic                              valid_reg, valid_next;
    logic [u16u8_pkg::M_DATA_W-1:0]    data_reg, data_next;
    logic [u16u8_pkg::M_USER_W-1:0]    user_reg, user_next;
    logic                              last_reg, last_next;
    logic [1:0]                        idx_reg, idx_next;
    logic                              load;
    logic                              at_last;

    always_comb begin
        load    = head_valid && (!valid_reg || m_tready);
        at_last = (idx_reg == head_job.last_idx);
        pop     = load && at_last;

        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = {6'd0, head_job.bytes_used, head_job.units_used,
                          head_job.bytes[idx_reg]};
            user_next  = {head_job.overflow, head_job.byte_valid};
            last_next  = at_last;
            idx_next   = at_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

// File: src/u16u8_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_checker
// Port-level checks of the transcoder output stream and configuration port.
// ----------------------------------------------------------------------------
module u16u8_props (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [u16u8_pkg::M_DATA_W-1:0]     m_tdata,
    input logic [u16u8_pkg::M_USER_W-1:0]     m_tuser,
    input logic                               m_tlast,
    input logic                               pready
);

    // A stalled output beat keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // An overflow report is a single beat with no byte.
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
        else $error("overflow beat malformed");

    // A beat without a byte closes its unit and carries a zero byte.
    a_nobyte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[7:0] == 8'd0))
        else $error("empty beat malformed");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready deasserted");

endmodule

bind utf16_to_utf8_transcoder u16u8_props u_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .pready   (pready)
);
